// ===== sv/aslot_pkg.sv =====
package aslot_pkg;

    // Default width of a slot index.
    localparam int unsigned DEF_SLOT_BITS = 16;

    // Widths of the stream fields.
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SIZE_W   = 16;
    localparam int unsigned OSLOT_W  = 16;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned OEND_W   = 16;

    typedef logic [CMD_W-1:0]    t_cmd;
    typedef logic [STATUS_W-1:0] t_status;

    // Request codes.
    localparam t_cmd CMD_ALLOC   = 2'd0;
    localparam t_cmd CMD_RESERVE = 2'd1;
    localparam t_cmd CMD_ALIGN   = 2'd2;
    localparam t_cmd CMD_QUERY   = 2'd3;

    // Result status codes.
    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_BAD_SIZE = 2'd2;

endpackage

// ===== sv/aligned_slot_allocator.sv =====
// Aligned stack slot allocator. Each request on the slave stream is one command
// (tuser) with a size (tdata); each one gives exactly one result on the master
// stream. Allocate hands out naturally aligned runs of 1, 2 or 4 slots from a
// spare single, a spare 2-aligned pair and the next 4-aligned quad, splitting
// the next larger fragment when needed; allocate of any other size acts as a
// reserve. Reserve places slots at the frame end, align pads the frame end up
// to a multiple of a power-of-two size (a full block when already aligned),
// and both rebuild the fragments from the new end. Query reports the slot an
// allocation would get and changes nothing. A request that would push the
// frame end or the next quad past the slot range reports overflow with slot 0
// and keeps the state; an align size that is not a power of two, or a query
// above four, reports an invalid size. The block takes one request per cycle
// while results are taken: the whole decision is a single pass of adds and
// compares between the request register and the result register, and the
// allocator state updates in the same edge that loads the result, so
// back-to-back requests see each other's effects. A result is loaded from
// the request register into the result register; a stalled result holds the
// request register, and with both registers full the slave side waits.
module aligned_slot_allocator #(
    parameter int unsigned SLOT_BITS = aslot_pkg::DEF_SLOT_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [15:0] size
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] cmd
    // Result stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [15:0] slot, [31:16] frame_end
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    // Candidate arithmetic is wide enough for the frame end plus a full
    // 16-bit size plus the rebuild offset, so overflow is seen, never wrapped.
    localparam int unsigned MAX_W = (SLOT_BITS > aslot_pkg::SIZE_W) ?
                                    SLOT_BITS : aslot_pkg::SIZE_W;
    localparam int unsigned W     = MAX_W + 2;
    localparam int unsigned XS    = W - SLOT_BITS;
    localparam int unsigned XZ    = W - aslot_pkg::SIZE_W;

    // Request register.
    logic                       r_in_vld;
    aslot_pkg::t_cmd            r_cmd;
    logic [aslot_pkg::SIZE_W-1:0] r_size;

    // Result register.
    logic                       r_out_vld;
    logic [aslot_pkg::OSLOT_W-1:0] r_out_slot;
    aslot_pkg::t_status         r_out_status;
    logic [aslot_pkg::OEND_W-1:0]  r_out_end;

    // Allocator state.
    logic [SLOT_BITS-1:0] r_single, r_pair, r_quad, r_end;
    logic                 r_single_vld, r_pair_vld;

    logic adv;
    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;

    // Single pass over one request.
    logic [W-1:0]       w_single, w_pair, w_quad, w_end, w_size;
    logic [W-1:0]       c_single, c_pair, c_quad, c_end, c_slot, c_cnt, c_top;
    logic               c_single_vld, c_pair_vld, c_rebuild;
    aslot_pkg::t_status c_status;
    logic               c_commit;

    assign w_single = {{XS{1'b0}}, r_single};
    assign w_pair   = {{XS{1'b0}}, r_pair};
    assign w_quad   = {{XS{1'b0}}, r_quad};
    assign w_end    = {{XS{1'b0}}, r_end};
    assign w_size   = {{XZ{1'b0}}, r_size};

    always_comb begin
        c_single     = w_single;
        c_pair       = w_pair;
        c_quad       = w_quad;
        c_end        = w_end;
        c_single_vld = r_single_vld;
        c_pair_vld   = r_pair_vld;
        c_slot       = '0;
        c_cnt        = w_size;
        c_top        = '0;
        c_rebuild    = 1'b0;
        c_status     = aslot_pkg::ST_OK;

        if (r_cmd == aslot_pkg::CMD_QUERY) begin
            if (r_size <= 16'd1 && r_single_vld) begin
                c_slot = w_single;
            end else if (r_size <= 16'd2 && r_pair_vld) begin
                c_slot = w_pair;
            end else if (r_size <= 16'd4) begin
                c_slot = w_quad;
            end else begin
                c_status = aslot_pkg::ST_BAD_SIZE;
            end
        end else if (r_cmd == aslot_pkg::CMD_ALLOC && r_size == 16'd1) begin
            if (r_single_vld) begin
                c_slot       = w_single;
                c_single_vld = 1'b0;
            end else if (r_pair_vld) begin
                c_slot       = w_pair;
                c_single     = w_pair + W'(1);
                c_single_vld = 1'b1;
                c_pair_vld   = 1'b0;
            end else begin
                c_slot       = w_quad;
                c_single     = w_quad + W'(1);
                c_single_vld = 1'b1;
                c_pair       = w_quad + W'(2);
                c_pair_vld   = 1'b1;
                c_quad       = w_quad + W'(4);
            end
        end else if (r_cmd == aslot_pkg::CMD_ALLOC && r_size == 16'd2) begin
            if (r_pair_vld) begin
                c_slot     = w_pair;
                c_pair_vld = 1'b0;
            end else begin
                c_slot     = w_quad;
                c_pair     = w_quad + W'(2);
                c_pair_vld = 1'b1;
                c_quad     = w_quad + W'(4);
            end
        end else if (r_cmd == aslot_pkg::CMD_ALLOC && r_size == 16'd4) begin
            c_slot = w_quad;
            c_quad = w_quad + W'(4);
        end else if (r_cmd == aslot_pkg::CMD_ALIGN) begin
            if (r_size == '0 || (r_size & (r_size - 16'd1)) != '0) begin
                c_status = aslot_pkg::ST_BAD_SIZE;
            end else begin
                c_cnt     = w_size - (w_end & (w_size - W'(1)));
                c_rebuild = 1'b1;
            end
        end else begin
            c_rebuild = 1'b1;
        end

        // Reserve and align: place at the end and rebuild from end mod 4.
        if (c_rebuild) begin
            c_slot = w_end;
            c_end  = w_end + c_cnt;
            unique case (c_end[1:0])
                2'd0: begin
                    c_single_vld = 1'b0;
                    c_pair_vld   = 1'b0;
                    c_quad       = c_end;
                end
                2'd1: begin
                    c_single     = c_end;
                    c_single_vld = 1'b1;
                    c_pair       = c_end + W'(1);
                    c_pair_vld   = 1'b1;
                    c_quad       = c_end + W'(3);
                end
                2'd2: begin
                    c_single_vld = 1'b0;
                    c_pair       = c_end;
                    c_pair_vld   = 1'b1;
                    c_quad       = c_end + W'(2);
                end
                default: begin
                    c_single     = c_end;
                    c_single_vld = 1'b1;
                    c_pair_vld   = 1'b0;
                    c_quad       = c_end + W'(1);
                end
            endcase
        end

        // Allocation of 1, 2 or 4 pushes the end out to cover the granted run.
        if (r_cmd == aslot_pkg::CMD_ALLOC &&
            (r_size == 16'd1 || r_size == 16'd2 || r_size == 16'd4)) begin
            c_top = c_slot + w_size;
            if (c_top > c_end) begin
                c_end = c_top;
            end
        end

        if (r_cmd != aslot_pkg::CMD_QUERY && c_status == aslot_pkg::ST_OK &&
            ((|c_end[W-1:SLOT_BITS]) || (|c_quad[W-1:SLOT_BITS]))) begin
            c_status = aslot_pkg::ST_OVERFLOW;
        end

        if (r_cmd != aslot_pkg::CMD_QUERY && c_status != aslot_pkg::ST_OK) begin
            c_slot = '0;
        end
    end

    assign c_commit = adv && r_cmd != aslot_pkg::CMD_QUERY &&
                      c_status == aslot_pkg::ST_OK;

    // Control and allocator state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_single     <= '0;
            r_single_vld <= 1'b0;
            r_pair       <= '0;
            r_pair_vld   <= 1'b0;
            r_quad       <= '0;
            r_end        <= '0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_vld <= i_s_axis_tvalid;
            end
            if (adv) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (c_commit) begin
                r_single     <= c_single[SLOT_BITS-1:0];
                r_single_vld <= c_single_vld;
                r_pair       <= c_pair[SLOT_BITS-1:0];
                r_pair_vld   <= c_pair_vld;
                r_quad       <= c_quad[SLOT_BITS-1:0];
                r_end        <= c_end[SLOT_BITS-1:0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_cmd  <= i_s_axis_tuser;
            r_size <= i_s_axis_tdata;
        end
        if (adv) begin
            r_out_slot   <= c_slot[aslot_pkg::OSLOT_W-1:0];
            r_out_status <= c_status;
            // Frame end after this step: the committed end, or the old one.
            r_out_end    <= c_commit ? c_end[aslot_pkg::OEND_W-1:0]
                                     : w_end[aslot_pkg::OEND_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {r_out_end, r_out_slot};
    assign o_m_axis_tuser  = r_out_status;

`ifndef SYNTHESIS
    // The next quad always starts on a 4-slot boundary.
    a_quad_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_quad[1:0] == 2'd0)
        else $error("quad pointer lost its 4-slot alignment");

    // A spare single slot is always the odd half of a pair.
    a_single_odd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_single_vld |-> r_single[0])
        else $error("spare single slot is not odd");

    // A spare pair always sits in the upper half of a quad.
    a_pair_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair_vld |-> (r_pair[1:0] == 2'd2))
        else $error("spare pair is not 2-aligned within a quad");

    // A failed request leaves the allocator state untouched.
    a_fail_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && c_status != aslot_pkg::ST_OK) |=>
            ($stable(r_end) && $stable(r_quad) && $stable(r_single_vld) &&
             $stable(r_pair_vld)))
        else $error("failed request changed allocator state");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Self-checking bench for the aligned slot allocator. Every request transfer
    // is run through a cycle-free model of the fragment pointers kept here; the
    // grant it predicts, or the hand-written grant of a known row, is queued.
    // Every result transfer is compared field by field with the oldest grant.

    // The highest slot index that a committed frame may reach.
    localparam logic [31:0] SLOT_TOP = (32'd1 << aslot_pkg::DEF_SLOT_BITS) - 32'd1;
    localparam int N_DIRECTED = 25;
    localparam int N_RANDOM   = 880;
    localparam int N_TOP      = 100;
    // Transfers to wait for before the receiver holds off once.
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_SHOWN   = 10;

    // One grant as it appears on the result stream.
    typedef struct packed {
        logic [15:0]        slot;
        aslot_pkg::t_status status;
        logic [15:0]        frame_end;
    } t_grant;

    // The allocator state. Values are kept wider than a slot index so that a
    // candidate state past the slot range can be seen and rejected.
    typedef struct {
        logic [31:0] single_slot;
        bit          single_ok;
        logic [31:0] pair_slot;
        bit          pair_ok;
        logic [31:0] quad_slot;
        logic [31:0] frame_end;
    } t_frag;

    // One row of the directed table. When known is set, want is the grant
    // written out by hand; otherwise the model supplies it.
    typedef struct {
        aslot_pkg::t_cmd cmd;
        logic [15:0]     size;
        bit              known;
        t_grant          want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = '0;    // [15:0] size
    logic [1:0]  i_s_axis_tuser = '0;    // [1:0] cmd
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;         // [15:0] slot, [31:16] frame_end
    logic [1:0]  o_m_axis_tuser;         // [1:0] status

    t_frag  frag;
    t_grant pending_grants[$];
    int     mismatch_count = 0;
    int     n_sent = 0;
    bit     tx_burst = 1'b0;

    // The directed table: the empty frame, the rejected sizes and overflow
    // first, then the first splits of a quad, reserves of zero, allocations
    // that fall back to a reserve, and aligns that hit an aligned end.
    t_dir_row dir_rows [N_DIRECTED] = '{
        '{aslot_pkg::CMD_QUERY, 16'd0, 1'b1, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_QUERY, 16'd5, 1'b1, '{16'd0, aslot_pkg::ST_BAD_SIZE, 16'd0}},
        '{aslot_pkg::CMD_QUERY, 16'hFFFF, 1'b1, '{16'd0, aslot_pkg::ST_BAD_SIZE, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'd0, 1'b1, '{16'd0, aslot_pkg::ST_BAD_SIZE, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'd3, 1'b1, '{16'd0, aslot_pkg::ST_BAD_SIZE, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'hFFFF, 1'b1, '{16'd0, aslot_pkg::ST_BAD_SIZE, 16'd0}},
        '{aslot_pkg::CMD_RESERVE, 16'hFFFF, 1'b1, '{16'd0, aslot_pkg::ST_OVERFLOW, 16'd0}},
        '{aslot_pkg::CMD_ALLOC, 16'hFFFF, 1'b1, '{16'd0, aslot_pkg::ST_OVERFLOW, 16'd0}},
        '{aslot_pkg::CMD_ALLOC, 16'd1, 1'b1, '{16'd0, aslot_pkg::ST_OK, 16'd1}},
        '{aslot_pkg::CMD_ALLOC, 16'd1, 1'b1, '{16'd1, aslot_pkg::ST_OK, 16'd2}},
        '{aslot_pkg::CMD_ALLOC, 16'd2, 1'b1, '{16'd2, aslot_pkg::ST_OK, 16'd4}},
        '{aslot_pkg::CMD_ALLOC, 16'd4, 1'b1, '{16'd4, aslot_pkg::ST_OK, 16'd8}},
        '{aslot_pkg::CMD_QUERY, 16'd1, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_RESERVE, 16'd0, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALLOC, 16'd0, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'd1, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_QUERY, 16'd0, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_QUERY, 16'd2, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_QUERY, 16'd4, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'd4, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'd4, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALLOC, 16'd3, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALLOC, 16'd2, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALLOC, 16'd1, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}},
        '{aslot_pkg::CMD_ALIGN, 16'd16, 1'b0, '{16'd0, aslot_pkg::ST_OK, 16'd0}}
    };

    aligned_slot_allocator u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sets the fragments from a new frame end, the same way a reserve or an
    // align leaves them: whatever lies between the end and the next 4-aligned
    // slot becomes the spare single and pair.
    function automatic t_frag refill_from_end(input t_frag f, input logic [31:0] fend);
        t_frag r;
        r = f;
        r.frame_end = fend;
        case (fend[1:0])
            2'd0: begin
                r.single_ok = 1'b0;
                r.pair_ok   = 1'b0;
                r.quad_slot = fend;
            end
            2'd1: begin
                r.single_slot = fend;
                r.single_ok   = 1'b1;
                r.pair_slot   = fend + 32'd1;
                r.pair_ok     = 1'b1;
                r.quad_slot   = fend + 32'd3;
            end
            2'd2: begin
                r.single_ok = 1'b0;
                r.pair_slot = fend;
                r.pair_ok   = 1'b1;
                r.quad_slot = fend + 32'd2;
            end
            default: begin
                r.single_slot = fend;
                r.single_ok   = 1'b1;
                r.pair_ok     = 1'b0;
                r.quad_slot   = fend + 32'd1;
            end
        endcase
        return r;
    endfunction

    // Works out the grant for one request and commits the new state when the
    // request succeeds. A failed request leaves the state alone.
    function automatic t_grant predict_grant(input aslot_pkg::t_cmd cmd,
                                             input logic [15:0] size);
        t_frag              nx;
        logic [31:0]        sz;
        logic [31:0]        slot;
        aslot_pkg::t_status status;
        t_grant             g;
        nx     = frag;
        sz     = {16'd0, size};
        slot   = '0;
        status = aslot_pkg::ST_OK;
        if (cmd == aslot_pkg::CMD_QUERY) begin
            // Size zero is treated as a single slot.
            if (sz <= 32'd1 && frag.single_ok) begin
                slot = frag.single_slot;
            end else if (sz <= 32'd2 && frag.pair_ok) begin
                slot = frag.pair_slot;
            end else if (sz <= 32'd4) begin
                slot = frag.quad_slot;
            end else begin
                status = aslot_pkg::ST_BAD_SIZE;
            end
        end else begin
            if (cmd == aslot_pkg::CMD_ALLOC && sz == 32'd1) begin
                if (nx.single_ok) begin
                    slot = nx.single_slot;
                    nx.single_ok = 1'b0;
                end else if (nx.pair_ok) begin
                    slot = nx.pair_slot;
                    nx.single_slot = slot + 32'd1;
                    nx.single_ok   = 1'b1;
                    nx.pair_ok     = 1'b0;
                end else begin
                    slot = nx.quad_slot;
                    nx.single_slot = slot + 32'd1;
                    nx.single_ok   = 1'b1;
                    nx.pair_slot   = slot + 32'd2;
                    nx.pair_ok     = 1'b1;
                    nx.quad_slot   = nx.quad_slot + 32'd4;
                end
            end else if (cmd == aslot_pkg::CMD_ALLOC && sz == 32'd2) begin
                if (nx.pair_ok) begin
                    slot = nx.pair_slot;
                    nx.pair_ok = 1'b0;
                end else begin
                    slot = nx.quad_slot;
                    nx.pair_slot = slot + 32'd2;
                    nx.pair_ok   = 1'b1;
                    nx.quad_slot = nx.quad_slot + 32'd4;
                end
            end else if (cmd == aslot_pkg::CMD_ALLOC && sz == 32'd4) begin
                slot = nx.quad_slot;
                nx.quad_slot = nx.quad_slot + 32'd4;
            end else if (cmd == aslot_pkg::CMD_ALIGN) begin
                if (sz == 32'd0 || (sz & (sz - 32'd1)) != 32'd0) begin
                    status = aslot_pkg::ST_BAD_SIZE;
                end else begin
                    // An end that is already aligned still pads a whole block.
                    slot = nx.frame_end;
                    nx = refill_from_end(nx,
                        nx.frame_end + sz - (nx.frame_end & (sz - 32'd1)));
                end
            end else begin
                // Reserve, and allocations of any size other than 1, 2 or 4.
                slot = nx.frame_end;
                nx = refill_from_end(nx, nx.frame_end + sz);
            end

            if (status == aslot_pkg::ST_OK && cmd == aslot_pkg::CMD_ALLOC
                    && (sz == 32'd1 || sz == 32'd2 || sz == 32'd4)) begin
                if (slot + sz > nx.frame_end) begin
                    nx.frame_end = slot + sz;
                end
            end
            if (status == aslot_pkg::ST_OK
                    && (nx.frame_end > SLOT_TOP || nx.quad_slot > SLOT_TOP)) begin
                status = aslot_pkg::ST_OVERFLOW;
            end
            if (status == aslot_pkg::ST_OK) begin
                frag = nx;
            end else begin
                slot = '0;
            end
        end
        g.slot      = slot[15:0];
        g.status    = status;
        g.frame_end = frag.frame_end[15:0];
        return g;
    endfunction

    // Picks one random request. Most are small allocations, queries, reserves
    // and aligns, so that the frame grows slowly and the fragments are split
    // in every order. The rest is noise: odd sizes, bad aligns, and reserves
    // sized so that they must run past the slot range.
    function automatic void pick_request(output aslot_pkg::t_cmd cmd,
                                         output logic [15:0] size);
        int r;
        int lo;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            cmd = aslot_pkg::CMD_ALLOC;
            case ($urandom_range(0, 3))
                0: size = 16'd1;
                1: size = 16'd2;
                2: size = 16'd4;
                default: size = 16'($urandom_range(1, 2));
            endcase
        end else if (r < 52) begin
            cmd  = aslot_pkg::CMD_ALLOC;
            size = 16'($urandom_range(0, 12));
        end else if (r < 70) begin
            cmd  = aslot_pkg::CMD_QUERY;
            size = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        end else if (r < 82) begin
            cmd  = aslot_pkg::CMD_RESERVE;
            size = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(10, 200))
                                               : 16'($urandom_range(0, 9));
        end else if (r < 94) begin
            cmd = aslot_pkg::CMD_ALIGN;
            case ($urandom_range(0, 5))
                0: size = 16'($urandom_range(0, 12));
                1: size = 16'($urandom);
                default: size = 16'd1 << $urandom_range(0, 5);
            endcase
        end else begin
            cmd = aslot_pkg::t_cmd'($urandom_range(0, 3));
            if (cmd == aslot_pkg::CMD_ALLOC || cmd == aslot_pkg::CMD_RESERVE) begin
                lo   = 65536 - int'(frag.frame_end);
                size = 16'($urandom_range((lo > 65535) ? 65535 : lo, 65535));
            end else begin
                size = 16'($urandom);
            end
        end
    endfunction

    // Offers one request until it is taken, queues its grant, then idles the
    // sender for a random gap. A gap of zero keeps tvalid high into the next
    // request, so tvalid is never lowered and raised in one step.
    task automatic send_request(input aslot_pkg::t_cmd cmd, input logic [15:0] size,
                                input bit known, input t_grant want);
        t_grant g;
        int     gap;
        int     r;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= size;
        i_s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_axis_tready) begin
            @(posedge i_clk);
        end
        g = predict_grant(cmd, size);
        pending_grants.push_back(known ? want : g);
        n_sent++;
        if (n_sent % 64 == 0) begin
            tx_burst = ($urandom_range(0, 3) == 0);
        end
        r = $urandom_range(0, 99);
        if (tx_burst || r < 55) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(5, 30);
        end
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Receiver. Stalls come in short and long runs, with quiet stretches in
    // which it takes every result. Once, after HOLD_AFTER request transfers,
    // it holds off long enough for both of the block's registers to fill and
    // the request side to back up, while the sender keeps offering.
    initial begin
        int  stall_left;
        int  cyc;
        bit  rx_quiet;
        bit  hold_done;
        stall_left = 0;
        cyc        = 0;
        rx_quiet   = 1'b0;
        hold_done  = 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) begin
            @(posedge i_clk);
        end
        forever begin
            cyc++;
            if (cyc % 128 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (!hold_done && n_sent >= HOLD_AFTER) begin
                hold_done = 1'b1;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else if (!rx_quiet && $urandom_range(0, 99) < 25) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(0, 2);
                i_m_axis_tready <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result checker: each result transfer must match the oldest queued grant.
    always @(posedge i_clk) begin
        t_grant got;
        t_grant want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.slot      = o_m_axis_tdata[15:0];
            got.frame_end = o_m_axis_tdata[31:16];
            got.status    = aslot_pkg::t_status'(o_m_axis_tuser);
            if (pending_grants.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN) begin
                    $display("%0t: result with nothing expected: slot %0d status %0d end %0d",
                             $realtime, got.slot, got.status, got.frame_end);
                end
            end else begin
                want = pending_grants.pop_front();
                if (got.slot !== want.slot || got.status !== want.status
                        || got.frame_end !== want.frame_end) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN) begin
                        $write("%0t: mismatch: expected slot %0d status %0d end %0d,",
                               $realtime, want.slot, want.status, want.frame_end);
                        $display(" got slot %0d status %0d end %0d",
                                 got.slot, got.status, got.frame_end);
                    end
                end
            end
        end
    end

    // Stimulus: reset, the directed table, a long random stretch low in the
    // slot range, then a short stretch just under the top of the range where
    // allocations start to overflow.
    initial begin
        aslot_pkg::t_cmd cmd;
        logic [15:0]     size;
        t_grant          none;
        int              top_gap;
        none = '0;
        frag = '{default: '0};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_request(dir_rows[i].cmd, dir_rows[i].size, dir_rows[i].known,
                         dir_rows[i].want);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            pick_request(cmd, size);
            send_request(cmd, size, 1'b0, none);
        end

        // The largest align there is, then a reserve that leaves a little
        // room below the top.
        send_request(aslot_pkg::CMD_ALIGN, 16'h8000, 1'b0, none);
        top_gap = $urandom_range(100, 300);
        if (int'(frag.frame_end) < 65535 - top_gap) begin
            send_request(aslot_pkg::CMD_RESERVE,
                         16'(65535 - top_gap - int'(frag.frame_end)), 1'b0, none);
        end
        for (int i = 0; i < N_TOP; i++) begin
            pick_request(cmd, size);
            send_request(cmd, size, 1'b0, none);
        end
        i_s_axis_tvalid <= 1'b0;

        while (pending_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("tb: errors");
        $finish;
    end

endmodule
